>>> hw/rtl/evm_pkg.sv
`default_nettype none

package evm_pkg;

  // CORDIC iterations; the arctangent table holds 24 entries.
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned NSTEP = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;

  // Pipeline stage indexes.
  localparam int unsigned ST_FOLD = 0;
  localparam int unsigned ST_SC   = NSTEP + 1;
  localparam int unsigned ST_A    = NSTEP + 2;
  localparam int unsigned ST_B    = NSTEP + 3;
  localparam int unsigned ST_C    = NSTEP + 4;
  localparam int unsigned ST_D    = NSTEP + 5;
  localparam int unsigned ST_E    = NSTEP + 6;
  localparam int unsigned NS      = NSTEP + 7;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [15:0] Q14_ONE     = 16'sd16384;

  typedef logic signed [33:0] cw_t;
  typedef logic signed [15:0] q14_t;
  typedef logic signed [29:0] p30_t;
  typedef logic signed [45:0] w46_t;
  typedef logic signed [47:0] p48_t;
  typedef logic signed [31:0] s32_t;

  typedef struct packed {
    cw_t        x;
    cw_t        y;
    cw_t        z;
    logic [1:0] q;
  } ang_t;

  typedef struct packed {
    s32_t px;
    s32_t py;
    s32_t pz;
  } pos_t;

  // Index 0 is the Y angle, 1 the X angle, 2 the Z angle.
  typedef struct packed {
    ang_t [2:0] ang;
    pos_t       pos;
  } cord_t;

  typedef struct packed {
    q14_t [2:0] c;
    q14_t [2:0] s;
    pos_t       pos;
  } sc_t;

  typedef struct packed {
    p30_t c1c3;
    p30_t s1s2;
    p30_t c1s2;
    p30_t c3s1;
    p30_t c1s3;
    p30_t s1s3;
    p30_t c2s3;
    p30_t c2c3;
    p30_t c2s1;
    p30_t c1c2;
    q14_t c3;
    q14_t s3;
    q14_t s2;
    pos_t pos;
  } sta_t;

  typedef struct packed {
    w46_t m0;
    w46_t m2;
    w46_t m3;
    w46_t m5;
    p30_t c2s3;
    p30_t c2c3;
    p30_t c2s1;
    p30_t c1c2;
    q14_t ms2;
    pos_t pos;
  } stb_t;

  typedef struct packed {
    q14_t [8:0] m;
    pos_t       pos;
  } stc_t;

  typedef struct packed {
    q14_t [8:0] m;
    p48_t [8:0] p;
  } std_t;

  typedef struct packed {
    q14_t [8:0] m;
    s32_t [2:0] t;
  } ste_t;

  // Rounded arctangent of 2^-i, with 2^32 as one full turn.
  function automatic cw_t atan_f(input int unsigned i);
    cw_t r;
    case (i)
      0:  r = 34'sd536870912;
      1:  r = 34'sd316933406;
      2:  r = 34'sd167458907;
      3:  r = 34'sd85004756;
      4:  r = 34'sd42667331;
      5:  r = 34'sd21354465;
      6:  r = 34'sd10679838;
      7:  r = 34'sd5340245;
      8:  r = 34'sd2670163;
      9:  r = 34'sd1335087;
      10: r = 34'sd667544;
      11: r = 34'sd333772;
      12: r = 34'sd166886;
      13: r = 34'sd83443;
      14: r = 34'sd41722;
      15: r = 34'sd20861;
      16: r = 34'sd10430;
      17: r = 34'sd5215;
      18: r = 34'sd2608;
      19: r = 34'sd1304;
      20: r = 34'sd652;
      21: r = 34'sd326;
      22: r = 34'sd163;
      23: r = 34'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic q14_t sat14(input logic signed [17:0] v);
    q14_t r;
    if (v > 18'sd16384) begin
      r = Q14_ONE;
    end else if (v < -18'sd16384) begin
      r = -Q14_ONE;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic s32_t sat32(input logic signed [35:0] v);
    s32_t r;
    if (v > 36'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -36'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/euler_yxz_view_matrix.sv
`default_nettype none

// Camera view matrix from a Q16.16 position and three binary Euler angles
// (Y, then X, then Z). The input channel carries one camera pose per
// transaction; the output channel carries the nine Q1.14 rotation entries
// and the three saturated Q16.16 translation entries.
// The datapath is a pipeline of NSTEP + 7 register stages (23 at the
// default of 16 steps): angle folding, one stage per CORDIC iteration for
// all three angles side by side, sine/cosine rounding, two product stages,
// entry rounding, position products and the translation sums.
// Throughput is one transaction per cycle while the receiver does not stall.
// Each stage has its own valid bit and holds only while the stage after it
// is full and stalled, so a stalled receiver lets empty stages fill before
// in_ready_o drops. Nothing is lost or repeated across a stall.
// Reset clears all valid bits; the pipeline is then empty and in_ready_o
// is high.
module euler_yxz_view_matrix (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic [31:0] pos_x_i,
  input  wire logic [31:0] pos_y_i,
  input  wire logic [31:0] pos_z_i,
  input  wire logic [15:0] angle_x_i,
  input  wire logic [15:0] angle_y_i,
  input  wire logic [15:0] angle_z_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic [15:0] ux_o,
  output      logic [15:0] uy_o,
  output      logic [15:0] uz_o,
  output      logic [15:0] vx_o,
  output      logic [15:0] vy_o,
  output      logic [15:0] vz_o,
  output      logic [15:0] wx_o,
  output      logic [15:0] wy_o,
  output      logic [15:0] wz_o,
  output      logic [31:0] tx_o,
  output      logic [31:0] ty_o,
  output      logic [31:0] tz_o
);

  logic [evm_pkg::NS-1:0] v_q;
  logic [evm_pkg::NS-1:0] en;

  evm_pkg::cord_t cs_q [0:evm_pkg::NSTEP];
  evm_pkg::cord_t fold_d;
  evm_pkg::sc_t   sc_q, sc_d;
  evm_pkg::sta_t  a_q, a_d;
  evm_pkg::stb_t  b_q, b_d;
  evm_pkg::stc_t  c_q, c_d;
  evm_pkg::std_t  d_q, d_d;
  evm_pkg::ste_t  e_q, e_d;

  // A stage may load when it is empty or when its content moves on.
  always_comb begin
    en[evm_pkg::NS-1] = !v_q[evm_pkg::NS-1] || out_ready_i;
    for (int k = evm_pkg::NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < evm_pkg::NS; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[evm_pkg::NS-1];

  // Fold each angle to a residual of at most an eighth of a turn.
  always_comb begin
    logic [15:0] a [3];
    logic [15:0] sh;
    logic [15:0] r;
    a[0] = angle_y_i;
    a[1] = angle_x_i;
    a[2] = angle_z_i;
    fold_d.pos.px = pos_x_i;
    fold_d.pos.py = pos_y_i;
    fold_d.pos.pz = pos_z_i;
    for (int k = 0; k < 3; k++) begin
      sh = a[k] + 16'd8192;
      r  = a[k] - {sh[15:14], 14'd0};
      fold_d.ang[k].q = sh[15:14];
      fold_d.ang[k].x = evm_pkg::CORDIC_GAIN;
      fold_d.ang[k].y = '0;
      fold_d.ang[k].z = evm_pkg::cw_t'($signed(r)) <<< 16;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[evm_pkg::ST_FOLD]) begin
      cs_q[0] <= fold_d;
    end
  end

  for (genvar g = 0; g < evm_pkg::NSTEP; g++) begin : g_cordic
    evm_pkg::cord_t nxt;

    always_comb begin
      evm_pkg::cw_t dx;
      evm_pkg::cw_t dy;
      nxt = cs_q[g];
      for (int k = 0; k < 3; k++) begin
        dx = cs_q[g].ang[k].y >>> g;
        dy = cs_q[g].ang[k].x >>> g;
        if (!cs_q[g].ang[k].z[33]) begin
          nxt.ang[k].x = cs_q[g].ang[k].x - dx;
          nxt.ang[k].y = cs_q[g].ang[k].y + dy;
          nxt.ang[k].z = cs_q[g].ang[k].z - evm_pkg::atan_f(g);
        end else begin
          nxt.ang[k].x = cs_q[g].ang[k].x + dx;
          nxt.ang[k].y = cs_q[g].ang[k].y - dy;
          nxt.ang[k].z = cs_q[g].ang[k].z + evm_pkg::atan_f(g);
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[g+1]) begin
        cs_q[g+1] <= nxt;
      end
    end
  end

  // Round to Q1.14 and undo the quadrant fold.
  always_comb begin
    evm_pkg::cw_t  xr;
    evm_pkg::cw_t  yr;
    evm_pkg::q14_t c;
    evm_pkg::q14_t s;
    sc_d.pos = cs_q[evm_pkg::NSTEP].pos;
    for (int k = 0; k < 3; k++) begin
      xr = (cs_q[evm_pkg::NSTEP].ang[k].x + 34'sd32768) >>> 16;
      yr = (cs_q[evm_pkg::NSTEP].ang[k].y + 34'sd32768) >>> 16;
      c  = evm_pkg::sat14(xr[17:0]);
      s  = evm_pkg::sat14(yr[17:0]);
      case (cs_q[evm_pkg::NSTEP].ang[k].q)
        2'd1: begin
          sc_d.c[k] = -s;
          sc_d.s[k] = c;
        end
        2'd2: begin
          sc_d.c[k] = -c;
          sc_d.s[k] = -s;
        end
        2'd3: begin
          sc_d.c[k] = s;
          sc_d.s[k] = -c;
        end
        default: begin
          sc_d.c[k] = c;
          sc_d.s[k] = s;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[evm_pkg::ST_SC]) begin
      sc_q <= sc_d;
    end
  end

  // Pairwise products of sines and cosines.
  always_comb begin
    a_d.c1c3 = evm_pkg::p30_t'(sc_q.c[0]) * evm_pkg::p30_t'(sc_q.c[2]);
    a_d.s1s2 = evm_pkg::p30_t'(sc_q.s[0]) * evm_pkg::p30_t'(sc_q.s[1]);
    a_d.c1s2 = evm_pkg::p30_t'(sc_q.c[0]) * evm_pkg::p30_t'(sc_q.s[1]);
    a_d.c3s1 = evm_pkg::p30_t'(sc_q.c[2]) * evm_pkg::p30_t'(sc_q.s[0]);
    a_d.c1s3 = evm_pkg::p30_t'(sc_q.c[0]) * evm_pkg::p30_t'(sc_q.s[2]);
    a_d.s1s3 = evm_pkg::p30_t'(sc_q.s[0]) * evm_pkg::p30_t'(sc_q.s[2]);
    a_d.c2s3 = evm_pkg::p30_t'(sc_q.c[1]) * evm_pkg::p30_t'(sc_q.s[2]);
    a_d.c2c3 = evm_pkg::p30_t'(sc_q.c[1]) * evm_pkg::p30_t'(sc_q.c[2]);
    a_d.c2s1 = evm_pkg::p30_t'(sc_q.c[1]) * evm_pkg::p30_t'(sc_q.s[0]);
    a_d.c1c2 = evm_pkg::p30_t'(sc_q.c[0]) * evm_pkg::p30_t'(sc_q.c[1]);
    a_d.c3   = sc_q.c[2];
    a_d.s3   = sc_q.s[2];
    a_d.s2   = sc_q.s[1];
    a_d.pos  = sc_q.pos;
  end

  always_ff @(posedge clk_i) begin
    if (en[evm_pkg::ST_A]) begin
      a_q <= a_d;
    end
  end

  // Three-factor terms, summed exactly in Q42.
  always_comb begin
    b_d.m0 = (evm_pkg::w46_t'(a_q.c1c3) <<< 14)
             + evm_pkg::w46_t'(a_q.s1s2) * evm_pkg::w46_t'(a_q.s3);
    b_d.m2 = evm_pkg::w46_t'(a_q.c1s2) * evm_pkg::w46_t'(a_q.s3)
             - (evm_pkg::w46_t'(a_q.c3s1) <<< 14);
    b_d.m3 = evm_pkg::w46_t'(a_q.s1s2) * evm_pkg::w46_t'(a_q.c3)
             - (evm_pkg::w46_t'(a_q.c1s3) <<< 14);
    b_d.m5 = evm_pkg::w46_t'(a_q.c1s2) * evm_pkg::w46_t'(a_q.c3)
             + (evm_pkg::w46_t'(a_q.s1s3) <<< 14);
    b_d.c2s3 = a_q.c2s3;
    b_d.c2c3 = a_q.c2c3;
    b_d.c2s1 = a_q.c2s1;
    b_d.c1c2 = a_q.c1c2;
    b_d.ms2  = -a_q.s2;
    b_d.pos  = a_q.pos;
  end

  always_ff @(posedge clk_i) begin
    if (en[evm_pkg::ST_B]) begin
      b_q <= b_d;
    end
  end

  function automatic evm_pkg::q14_t r42(input evm_pkg::w46_t v);
    evm_pkg::w46_t t;
    t = (v + 46'sd134217728) >>> 28;
    return evm_pkg::sat14(t[17:0]);
  endfunction

  function automatic evm_pkg::q14_t r28(input evm_pkg::p30_t v);
    logic signed [30:0] t;
    t = (31'(v) + 31'sd8192) >>> 14;
    return evm_pkg::sat14(t[17:0]);
  endfunction

  always_comb begin
    c_d.m[0] = r42(b_q.m0);
    c_d.m[1] = r28(b_q.c2s3);
    c_d.m[2] = r42(b_q.m2);
    c_d.m[3] = r42(b_q.m3);
    c_d.m[4] = r28(b_q.c2c3);
    c_d.m[5] = r42(b_q.m5);
    c_d.m[6] = r28(b_q.c2s1);
    c_d.m[7] = b_q.ms2;
    c_d.m[8] = r28(b_q.c1c2);
    c_d.pos  = b_q.pos;
  end

  always_ff @(posedge clk_i) begin
    if (en[evm_pkg::ST_C]) begin
      c_q <= c_d;
    end
  end

  // Each rotation entry times its position component.
  always_comb begin
    d_d.m = c_q.m;
    for (int r = 0; r < 3; r++) begin
      d_d.p[3*r]   = evm_pkg::p48_t'(c_q.m[3*r])   * evm_pkg::p48_t'(c_q.pos.px);
      d_d.p[3*r+1] = evm_pkg::p48_t'(c_q.m[3*r+1]) * evm_pkg::p48_t'(c_q.pos.py);
      d_d.p[3*r+2] = evm_pkg::p48_t'(c_q.m[3*r+2]) * evm_pkg::p48_t'(c_q.pos.pz);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[evm_pkg::ST_D]) begin
      d_q <= d_d;
    end
  end

  always_comb begin
    logic signed [49:0] sum;
    logic signed [49:0] sh;
    e_d.m = d_q.m;
    for (int r = 0; r < 3; r++) begin
      sum = -(50'($signed(d_q.p[3*r])) + 50'($signed(d_q.p[3*r+1]))
              + 50'($signed(d_q.p[3*r+2])));
      sh  = (sum + 50'sd8192) >>> 14;
      e_d.t[r] = evm_pkg::sat32(sh[35:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[evm_pkg::ST_E]) begin
      e_q <= e_d;
    end
  end

  assign ux_o = e_q.m[0];
  assign uy_o = e_q.m[1];
  assign uz_o = e_q.m[2];
  assign vx_o = e_q.m[3];
  assign vy_o = e_q.m[4];
  assign vz_o = e_q.m[5];
  assign wx_o = e_q.m[6];
  assign wy_o = e_q.m[7];
  assign wz_o = e_q.m[8];
  assign tx_o = e_q.t[0];
  assign ty_o = e_q.t[1];
  assign tz_o = e_q.t[2];

endmodule

`default_nettype wire

>>> hw/rtl/evm_checker.sv
`default_nettype none

module evm_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [15:0] ux_o,
  input wire logic [15:0] vy_o,
  input wire logic [15:0] wy_o,
  input wire logic [31:0] tx_o
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(ux_o) && $stable(tx_o))
    else $error("output changed while stalled");

  // With no result waiting, every stage can move, so input is taken.
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");

  // Rotation entries ux, vy and wy stay within plus or minus one in Q1.14.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(ux_o) <= 16'sd16384) && ($signed(ux_o) >= -16'sd16384)
      && ($signed(vy_o) <= 16'sd16384) && ($signed(vy_o) >= -16'sd16384)
      && ($signed(wy_o) <= 16'sd16384) && ($signed(wy_o) >= -16'sd16384))
    else $error("rotation entry out of range");

  // No result is valid right after reset.
  a_no_early: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid right after reset");

endmodule

bind euler_yxz_view_matrix evm_checker u_evm_checker (.*);

`default_nettype wire
